/* hw/rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and codes for the sorted matrix staircase search core.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned IDX_W  = 11;
  localparam int unsigned DIM_W  = 6;
  localparam int unsigned DATA_W = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REPORT
  } state_t;

endpackage

/* hw/rtl/sms_store.sv */
// ----------------------------------------------------------------------------
// sms_store
// Matrix element memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sms_store #(
  parameter int unsigned ADDR_W = 10
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [sms_pkg::DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic signed [sms_pkg::DATA_W-1:0] rd_data
);
  import sms_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sorted_matrix_staircase_search_core.sv */
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search_core
// Staircase search over a row- and column-sorted matrix of signed words.
//
// An item is a transfer at a clock edge with start high and busy low.
// A load (operation 0) writes value at (row_index, col_index) in that cycle
// and gives no result; loads outside MAX_ROWS by MAX_COLS are dropped.
// A query (operation 1) walks from the top-right element in use, one element
// per cycle: one memory read and one signed compare per step. The walk ends
// on a hit or when it leaves the matrix and is followed by a report state;
// an empty matrix goes straight to the report state.
// busy stays high until the report cycle has passed; the next item may be
// taken in the cycle after done.
// done is high for exactly one cycle with found valid; the receiver cannot
// stall and must take it then.
// cfg_write writes cfg_data to rows_in_use (index 0) or cols_in_use
// (index 1) at once; write only while busy is low.
// Reset returns the sequencer to idle and both dimensions to 32. Memory
// contents are not cleared; read only written elements.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search_core #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [4:0]                        row_index,
  input  logic [4:0]                        col_index,
  input  logic signed [sms_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic                              found,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [sms_pkg::DIM_W-1:0]         cfg_data
);
  import sms_pkg::*;

  localparam int unsigned RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ADDR_W = RW + CW;

  state_t state, state_next;

  logic [DIM_W-1:0]         rows_in_use, cols_in_use;
  logic [DIM_W-1:0]         rows_cl, cols_cl;
  logic [DIM_W-1:0]         rows_lim;
  logic [DIM_W-1:0]         r, r_next;
  logic [DIM_W-1:0]         c, c_next;
  logic signed [DATA_W-1:0] target;
  logic                     hit, hit_next;
  logic                     step_end;
  logic                     accept, query_go, empty;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_row_w, wr_col_w, rd_row_w, rd_col_w;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  assign accept   = start && (state == ST_IDLE);
  assign query_go = accept && (operation == OP_QUERY);

  assign rows_cl = (IDX_W'(rows_in_use) > IDX_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_in_use;
  assign cols_cl = (IDX_W'(cols_in_use) > IDX_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_in_use;
  assign empty   = (rows_cl == '0) || (cols_cl == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= DIM_W'(32);
      cols_in_use <= DIM_W'(32);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default:  rows_in_use <= rows_in_use;
      endcase
    end
  end

  // Walk step: one compare against the element read last cycle
  always_comb begin
    r_next   = r;
    c_next   = c;
    hit_next = hit;
    step_end = 1'b0;
    case (state)
      ST_IDLE: begin
        if (query_go) begin
          r_next   = '0;
          c_next   = cols_cl;
          hit_next = 1'b0;
        end
      end
      ST_WALK: begin
        if (target == rd_data) begin
          hit_next = 1'b1;
          step_end = 1'b1;
        end else if (target < rd_data) begin
          c_next   = c - 1'b1;
          step_end = (c_next == '0);
        end else begin
          r_next   = r + 1'b1;
          step_end = (r_next == rows_lim);
        end
      end
      default: begin
        r_next = r;
      end
    endcase
  end

  assign rd_row_w = IDX_W'(r_next);
  assign rd_col_w = IDX_W'(c_next - 1'b1);
  assign rd_addr  = {rd_row_w[RW-1:0], rd_col_w[CW-1:0]};

  assign wr_row_w = IDX_W'(row_index);
  assign wr_col_w = IDX_W'(col_index);
  assign wr_addr  = {wr_row_w[RW-1:0], wr_col_w[CW-1:0]};
  assign wr_en    = accept && (operation == OP_LOAD) &&
                    (wr_row_w < IDX_W'(MAX_ROWS)) && (wr_col_w < IDX_W'(MAX_COLS));

  sms_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_go) begin
          state_next = empty ? ST_REPORT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (step_end) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    r   <= r_next;
    c   <= c_next;
    hit <= hit_next;
    if (query_go) begin
      target   <= value;
      rows_lim <= rows_cl;
    end
  end

  always_comb begin
    busy  = (state != ST_IDLE);
    done  = (state == ST_REPORT);
    found = hit;
  end

endmodule

/* hw/rtl/sms_checker.sv */
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks on the staircase search core, bound to the top level.
// ----------------------------------------------------------------------------
module sms_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic done
);
  import sms_pkg::*;

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_query_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_QUERY)) |=> busy)
    else $error("query transfer did not raise busy");

  a_load_quiet : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_LOAD)) |=> (!busy && !done))
    else $error("load transfer caused activity");

  a_fall_after_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind sorted_matrix_staircase_search_core sms_checker u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_matrix_staircase_search_core. Loads sorted
// (and occasionally unsorted) matrices of many shapes, fires search queries
// at them and compares every found flag against an in-bench staircase walk.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sms_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

  class search_board;
    logic signed [31:0] cells [1024];
    logic [5:0] row_limit;
    logic [5:0] col_limit;
    bit found_due [$];
    int unsigned errors;
    int unsigned loads;
    int unsigned queries;
    int unsigned hits;

    function new();
      row_limit = 6'd32;
      col_limit = 6'd32;
    endfunction

    function void set_dim(logic idx, logic [5:0] v);
      if (idx == REG_ROWS) row_limit = v;
      else col_limit = v;
    endfunction

    function bit walk(logic signed [31:0] target);
      int unsigned nr, nc, r, c;
      logic signed [31:0] e;
      nr = (row_limit > 32) ? 32 : row_limit;
      nc = (col_limit > 32) ? 32 : col_limit;
      r = 0;
      c = nc;
      while (r < nr && c > 0) begin
        e = cells[r * 32 + c - 1];
        if (target == e) return 1'b1;
        else if (target < e) c--;
        else r++;
      end
      return 1'b0;
    endfunction

    function void take_item(logic op, logic [4:0] r, logic [4:0] c, logic signed [31:0] v);
      bit f;
      if (op == OP_LOAD) begin
        cells[{r, c}] = v;
        loads++;
      end else begin
        f = walk(v);
        found_due.push_back(f);
        queries++;
        if (f) hits++;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_found(logic f);
      bit want;
      if (found_due.size() == 0) begin
        report($sformatf("result with no query outstanding: found=%0b", f));
      end else begin
        want = found_due.pop_front();
        if (f !== want)
          report($sformatf("found mismatch: expected %0b, got %0b", want, f));
      end
    endfunction

    function int unsigned pending();
      return found_due.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = OP_LOAD;
  logic [4:0] row_index = '0;
  logic [4:0] col_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic done;
  logic found;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_ROWS;
  logic [DIM_W-1:0] cfg_data = '0;

  search_board board = new();
  int unsigned idle_pct = 0;
  int unsigned stim_items = 0;
  int unsigned shapes = 0;
  int unsigned stall_cycles = 0;

  sorted_matrix_staircase_search_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .row_index(row_index), .col_index(col_index),
    .value(value), .done(done), .found(found),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_found(found);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer or result for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic transfer(logic op, logic [4:0] r, logic [4:0] c, logic signed [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    row_index <= r;
    col_index <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_item(op, r, c, v);
    stim_items++;
  endtask

  // hold off until every outstanding query has reported
  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_dim(logic idx, int unsigned v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 6'(v);
    @(posedge clk);
    board.set_dim(idx, 6'(v));
  endtask

  task automatic set_dims(int unsigned nr, int unsigned nc);
    drain();
    write_dim(REG_ROWS, nr);
    write_dim(REG_COLS, nc);
    cfg_write <= 1'b0;
    shapes++;
  endtask

  function automatic longint cell_at(int unsigned r, int unsigned c);
    return longint'(board.cells[r * 32 + c]);
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return $urandom_range(1, 6);
    if (k < 72) return $urandom_range(7, 12);
    if (k < 77) return $urandom_range(13, 32);
    if (k < 87) return $urandom_range(33, 63);
    if (k < 95) return 0;
    return 32;
  endfunction

  task automatic run_phase(int unsigned rdim, int unsigned cdim, int unsigned n_items,
                           bit sorted);
    int unsigned nr, nc, r, c, i, k, span;
    longint base, prev, cur;
    logic signed [31:0] t;
    set_dims(rdim, cdim);
    nr = (rdim > 32) ? 32 : rdim;
    nc = (cdim > 32) ? 32 : cdim;
    case ($urandom_range(0, 3))
      0: span = 1;
      1: span = 4;
      2: span = 1000;
      default: span = 1 << 20;
    endcase
    case ($urandom_range(0, 3))
      0: base = longint'(MIN32);
      1: base = longint'(int'($urandom));
      default: base = longint'($urandom_range(0, 2000)) - 1000;
    endcase
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        if (!sorted) begin
          cur = longint'(int'($urandom));
        end else if (r == 0 && c == 0) begin
          cur = base;
        end else begin
          prev = (r > 0) ? cell_at(r - 1, c) : cell_at(r, c - 1);
          if (r > 0 && c > 0 && cell_at(r, c - 1) > prev) prev = cell_at(r, c - 1);
          cur = prev + longint'($urandom_range(0, span));
          if (cur > longint'(MAX32)) cur = longint'(MAX32);
        end
        transfer(OP_LOAD, 5'(r), 5'(c), cur[31:0]);
      end
    end
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 3) wait_results();
      k = $urandom_range(0, 99);
      if (k < 12) begin
        transfer(OP_LOAD, 5'($urandom), 5'($urandom), $urandom);
      end else begin
        k = $urandom_range(0, 99);
        if (nr > 0 && nc > 0 && k < 70) begin
          t = board.cells[$urandom_range(0, nr - 1) * 32 + $urandom_range(0, nc - 1)];
          if (k >= 50) t = $urandom_range(0, 1) ? t + 1 : t - 1;
        end else if (k < 85) begin
          t = $urandom;
        end else begin
          case ($urandom_range(0, 3))
            0: t = MIN32;
            1: t = MAX32;
            2: t = '0;
            default: t = -1;
          endcase
        end
        transfer(OP_QUERY, 5'($urandom), 5'($urandom), t);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty matrix in either dimension
    set_dims(0, 5);
    transfer(OP_QUERY, 5'd0, 5'd0, MIN32);
    set_dims(3, 0);
    transfer(OP_QUERY, 5'd31, 5'd31, MAX32);

    // two by two with the value extremes
    set_dims(2, 2);
    transfer(OP_LOAD, 5'd0, 5'd0, MIN32);
    transfer(OP_LOAD, 5'd0, 5'd1, 32'sd0);
    transfer(OP_LOAD, 5'd1, 5'd0, -32'sd1);
    transfer(OP_LOAD, 5'd1, 5'd1, MAX32);
    transfer(OP_LOAD, 5'd31, 5'd31, 32'sh5555_5555);
    transfer(OP_QUERY, 5'd0, 5'd0, MIN32);
    transfer(OP_QUERY, 5'd0, 5'd0, MAX32);
    transfer(OP_QUERY, 5'd0, 5'd0, 32'sd0);
    transfer(OP_QUERY, 5'd0, 5'd0, -32'sd1);
    transfer(OP_QUERY, 5'd0, 5'd0, 32'sd5);
    transfer(OP_QUERY, 5'd0, 5'd0, -32'sd2);

    // unsorted contents: the walk steps past a value that is present
    transfer(OP_LOAD, 5'd0, 5'd0, 32'sd100);
    transfer(OP_QUERY, 5'd0, 5'd0, 32'sd100);
    transfer(OP_QUERY, 5'd0, 5'd0, 32'sd0);

    // tall fill with an oversized row count, then random shapes
    phase = 0;
    run_phase($urandom_range(33, 63), 12, 40, 1'b1);
    while (stim_items < RANDOM_ITEMS || phase < 2) begin
      phase++;
      case (phase % 4)
        1: idle_pct = 77;
        2: idle_pct = 7;
        default: idle_pct = 0;
      endcase
      run_phase(pick_dim(), pick_dim(), $urandom_range(10, 40), $urandom_range(0, 99) < 85);
    end

    idle_pct = 0;
    wait_results();
    repeat (70) @(posedge clk);
    $display("Covered %0d loads and %0d queries (%0d found) over %0d matrix shapes,",
             board.loads, board.queries, board.hits, shapes);
    $display("empty, oversized and unsorted matrices included; %0d mismatches.",
             board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
